/* hdl/sws_pkg.sv */
`default_nettype none
package sws_pkg;

    localparam int WINDOW_SLOTS_DEF  = 8;
    localparam int MAX_SEG_BYTES_DEF = 1024;

    localparam logic [15:0] RTO_RESET     = 16'd1000;
    localparam logic [31:0] FIRST_RESET   = 32'd1;
    localparam logic [15:0] PEER_WIN_INIT = 16'd65535;

    // command codes
    localparam logic [1:0] CMD_OFFER = 2'd0;
    localparam logic [1:0] CMD_ACK   = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_SENT   = 3'd0;
    localparam logic [2:0] KIND_FULL   = 3'd1;
    localparam logic [2:0] KIND_FLOW   = 3'd2;
    localparam logic [2:0] KIND_ACKED  = 3'd3;
    localparam logic [2:0] KIND_RETX   = 3'd4;
    localparam logic [2:0] KIND_IDLE   = 3'd5;

    // configuration register indexes
    localparam logic CFG_RTO   = 1'b0;
    localparam logic CFG_FIRST = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [10:0] seg_len;
        logic [31:0] ack_number;
        logic [15:0] adv_window;
    } sws_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] seq_out;
        logic [10:0] len_out;
        logic [7:0]  retries;
        logic [3:0]  in_flight;
        logic [15:0] bytes_out;
        logic        last;
    } sws_out_t;

    // controller to datapath
    typedef struct packed {
        logic start;      // latch item
        logic offer;      // do offer and emit
        logic ack_step;   // release base slot
        logic ack_done;   // emit ack result
        logic tick_inc;   // bump time
        logic scan_step;  // examine scan slot
        logic flush_last; // emit held retransmit as final word
        logic idle_emit;  // emit tick idle
    } sws_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       base_covered;
        logic       any_used;
        logic       scan_more;
        logic       emitted;
        logic       out_busy;
    } sws_stat_t;

endpackage
`default_nettype wire

/* hdl/sws_datapath.sv */
`default_nettype none
module sws_datapath import sws_pkg::*; #(
    parameter int WINDOW_SLOTS  = WINDOW_SLOTS_DEF,
    parameter int MAX_SEG_BYTES = MAX_SEG_BYTES_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire sws_in_t  item,
    input  wire sws_cmd_t ctl,
    input  wire logic     cfg_we,
    input  wire logic     cfg_idx,
    input  wire logic [31:0] cfg_data,
    output sws_stat_t     stat,
    output logic          out_valid,
    input  wire logic     out_ready,
    output sws_out_t      out_word
);
    localparam int IW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int CW = $clog2(WINDOW_SLOTS + 1);
    localparam logic [10:0] MAXLEN = 11'((MAX_SEG_BYTES > 2047) ? 2047 : MAX_SEG_BYTES);

    logic [31:0] seq_reg [WINDOW_SLOTS];
    logic [10:0] len_reg [WINDOW_SLOTS];
    logic [31:0] sent_reg [WINDOW_SLOTS];
    logic [7:0]  retr_reg [WINDOW_SLOTS];

    sws_in_t       item_reg, item_next;
    logic [15:0]   rto_reg, rto_next;
    logic [IW-1:0] base_reg, base_next;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [31:0]   nseq_reg, nseq_next;
    logic [15:0]   bytes_reg, bytes_next;
    logic [15:0]   peer_reg, peer_next;
    logic [31:0]   now_reg, now_next;
    logic          emitted_reg, emitted_next;
    logic          out_valid_reg, out_valid_next;
    sws_out_t      out_reg, out_next;
    sws_out_t      hold_reg, hold_next;

    // slot index arithmetic
    function automatic logic [IW-1:0] wrap(input logic [IW:0] v);
        logic [IW:0] r;
        r = (v >= (IW+1)'(WINDOW_SLOTS)) ? v - (IW+1)'(WINDOW_SLOTS) : v;
        return r[IW-1:0];
    endfunction

    logic [IW-1:0] tail_idx, scan_idx, base_step_idx;
    logic [10:0]   clamp_len;
    logic [16:0]   flow_sum;
    logic          full;
    logic          fits;
    logic [31:0]   base_seq;
    logic [31:0]   age;
    logic          expired;
    logic [7:0]    retr_bump;
    sws_out_t      base_word, sent_word, retx_word;

    assign tail_idx      = wrap({1'b0, base_reg} + (IW+1)'(used_reg));
    assign scan_idx      = wrap({1'b0, base_reg} + (IW+1)'(scan_reg));
    assign base_step_idx = wrap({1'b0, base_reg} + (IW+1)'(1));
    assign clamp_len = (item_reg.seg_len > MAXLEN) ? MAXLEN : item_reg.seg_len;
    assign flow_sum  = {1'b0, bytes_reg} + {6'd0, clamp_len};
    assign full      = used_reg >= CW'(WINDOW_SLOTS);
    assign fits      = flow_sum <= {1'b0, peer_reg};
    assign base_seq  = (used_reg != '0) ? seq_reg[base_reg] : nseq_reg;
    assign age       = now_reg - sent_reg[scan_idx];
    assign expired   = age >= {16'd0, rto_reg};
    assign retr_bump = (retr_reg[scan_idx] == 8'hff) ? 8'hff : retr_reg[scan_idx] + 8'd1;

    assign stat.cmd          = item_reg.cmd;
    assign stat.base_covered = (item_reg.ack_number - seq_reg[base_reg]) < 32'h8000_0000;
    assign stat.any_used     = used_reg != '0;
    assign stat.scan_more    = scan_reg < used_reg;
    assign stat.emitted      = emitted_reg;
    assign stat.out_busy     = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // candidate result words
    always_comb begin
        base_word           = '0;
        base_word.seq_out   = base_seq;
        base_word.in_flight = 4'(used_reg);
        base_word.bytes_out = bytes_reg;
        base_word.last      = 1'b1;

        sent_word           = '0;
        sent_word.kind      = KIND_SENT;
        sent_word.seq_out   = nseq_reg;
        sent_word.len_out   = clamp_len;
        sent_word.retries   = 8'd1;
        sent_word.in_flight = 4'(used_reg + CW'(1));
        sent_word.bytes_out = flow_sum[15:0];
        sent_word.last      = 1'b1;

        retx_word           = '0;
        retx_word.kind      = KIND_RETX;
        retx_word.seq_out   = seq_reg[scan_idx];
        retx_word.len_out   = len_reg[scan_idx];
        retx_word.retries   = retr_bump;
        retx_word.in_flight = 4'(used_reg);
        retx_word.bytes_out = bytes_reg;
        retx_word.last      = 1'b0;
    end

    // next state
    always_comb begin
        item_next      = ctl.start ? item : item_reg;
        rto_next       = rto_reg;
        base_next      = base_reg;
        used_next      = used_reg;
        scan_next      = scan_reg;
        nseq_next      = nseq_reg;
        bytes_next     = bytes_reg;
        peer_next      = peer_reg;
        now_next       = now_reg;
        emitted_next   = emitted_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        hold_next      = hold_reg;

        if (out_valid_reg && out_ready) out_valid_next = 1'b0;
        if (cfg_we) begin
            if (cfg_idx == CFG_RTO) rto_next = cfg_data[15:0];
            else if (used_reg == '0) nseq_next = cfg_data;
        end
        if (ctl.start) begin
            scan_next    = '0;
            emitted_next = 1'b0;
            if (item.cmd == CMD_ACK) peer_next = item.adv_window;
        end
        // offer: refuse or record in the tail slot
        if (ctl.offer) begin
            out_valid_next = 1'b1;
            out_next       = base_word;
            if (full) out_next.kind = KIND_FULL;
            else if (!fits) out_next.kind = KIND_FLOW;
            else begin
                nseq_next  = nseq_reg + 32'd1;
                used_next  = used_reg + CW'(1);
                bytes_next = flow_sum[15:0];
                out_next   = sent_word;
            end
        end
        // release one covered slot from the base
        if (ctl.ack_step) begin
            bytes_next = bytes_reg - {5'd0, len_reg[base_reg]};
            used_next  = used_reg - CW'(1);
            base_next  = base_step_idx;
        end
        if (ctl.ack_done) begin
            out_valid_next = 1'b1;
            out_next       = base_word;
            out_next.kind  = KIND_ACKED;
        end
        if (ctl.tick_inc) now_next = now_reg + 32'd1;
        // expired slot goes to the hold word, the previous one goes out
        if (ctl.scan_step) begin
            scan_next = scan_reg + CW'(1);
            if (expired) begin
                emitted_next = 1'b1;
                hold_next    = retx_word;
                if (emitted_reg) begin
                    out_next       = hold_reg;
                    out_valid_next = 1'b1;
                end
            end
        end
        if (ctl.flush_last) begin
            out_next       = hold_reg;
            out_next.last  = 1'b1;
            out_valid_next = 1'b1;
        end
        if (ctl.idle_emit) begin
            out_valid_next = 1'b1;
            out_next       = base_word;
            out_next.kind  = KIND_IDLE;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rto_reg <= RTO_RESET;
            base_reg <= '0; used_reg <= '0; scan_reg <= '0;
            nseq_reg <= FIRST_RESET; bytes_reg <= '0;
            peer_reg <= PEER_WIN_INIT; now_reg <= '0;
            emitted_reg <= 1'b0; out_valid_reg <= 1'b0;
        end else begin
            rto_reg <= rto_next;
            base_reg <= base_next; used_reg <= used_next; scan_reg <= scan_next;
            nseq_reg <= nseq_next; bytes_reg <= bytes_next;
            peer_reg <= peer_next; now_reg <= now_next;
            emitted_reg <= emitted_next; out_valid_reg <= out_valid_next;
        end
    end

    // item and slot storage, result words
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        out_reg  <= out_next;
        hold_reg <= hold_next;
        if (ctl.offer && !full && fits) begin
            seq_reg[tail_idx] <= nseq_reg; len_reg[tail_idx] <= clamp_len;
            sent_reg[tail_idx] <= now_reg; retr_reg[tail_idx] <= 8'd1;
        end else if (ctl.scan_step && expired) begin
            sent_reg[scan_idx] <= now_reg; retr_reg[scan_idx] <= retr_bump;
        end
    end
endmodule
`default_nettype wire

/* hdl/sws_ctrl.sv */
`default_nettype none
module sws_ctrl import sws_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire sws_stat_t stat,
    output sws_cmd_t       ctl
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DISP = 3'd1;
    localparam logic [2:0] ST_ACK  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;

    // new word only when idle and no result pending
    assign in_ready = (state_reg == ST_IDLE) && !stat.out_busy;

    always_comb begin
        state_next = state_reg;
        ctl = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_ready) begin
                    ctl.start = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                case (stat.cmd)
                    CMD_OFFER: begin
                        ctl.offer = 1'b1; state_next = ST_IDLE;
                    end
                    CMD_ACK:  state_next = ST_ACK;
                    CMD_TICK: begin
                        ctl.tick_inc = 1'b1; state_next = ST_SCAN;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_ACK: begin
                if (stat.any_used && stat.base_covered) ctl.ack_step = 1'b1;
                else if (!stat.out_busy) begin
                    ctl.ack_done = 1'b1; state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!stat.out_busy) begin
                    if (stat.scan_more) ctl.scan_step = 1'b1;
                    else state_next = ST_FIN;
                end
            end
            // output is free here, scan only leaves once it is
            ST_FIN: begin
                if (stat.emitted) ctl.flush_last = 1'b1;
                else ctl.idle_emit = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end
endmodule
`default_nettype wire

/* hdl/sliding_window_sender.sv */
`default_nettype none
// channel | direction | handshake             | word
// s_      | in        | s_valid / s_ready     | s_data (sws_in_t)
// m_      | out       | m_valid / m_ready     | m_data (sws_out_t)
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
// offer: latch, then record or refuse and emit; unknown command: latch and drop; ack:
// release covered slots one by one, then emit; tick: scan each in-flight slot, each
// retransmit waiting until the previous word is taken. the ack and scan states walk the
// slots; a retransmit is held one slot so the final one can carry last.
// synchronous active-low reset; no clearing pass, free slots are tracked by count.
// a stalled output holds the controller; input is refused until the result leaves.
module sliding_window_sender import sws_pkg::*; #(
    parameter int WINDOW_SLOTS  = WINDOW_SLOTS_DEF,
    parameter int MAX_SEG_BYTES = MAX_SEG_BYTES_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire sws_in_t    s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output sws_out_t        m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [0:0] cfg_index,
    input  wire logic [31:0] cfg_data
);
    sws_cmd_t  ctl;
    sws_stat_t stat;

    assign cfg_ready = 1'b1;

    sws_ctrl u_ctrl (
        .aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready),
        .stat, .ctl
    );

    sws_datapath #(.WINDOW_SLOTS(WINDOW_SLOTS), .MAX_SEG_BYTES(MAX_SEG_BYTES)) u_dp (
        .aclk, .aresetn, .item(s_data), .ctl,
        .cfg_we(cfg_valid), .cfg_idx(cfg_index[0]), .cfg_data,
        .stat, .out_valid(m_valid), .out_ready(m_ready), .out_word(m_data)
    );

    // occupancy never above the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.in_flight <= 4'(WINDOW_SLOTS))
        else $error("in_flight exceeds window");
    // held result stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed under stall");
    // no intake while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("accept during stall");
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import sws_pkg::*;

    localparam int SLOTS    = WINDOW_SLOTS_DEF;
    localparam int MAX_SEG  = MAX_SEG_BYTES_DEF;
    localparam int DRAIN_CYCLES = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    sws_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    sws_out_t    m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    sliding_window_sender i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // shadow copy of the sender state
    logic [15:0] rto_reg;
    logic [31:0] first_seq_reg;
    logic        free_slot [SLOTS];
    logic [31:0] seq_slot [SLOTS];
    logic [10:0] len_slot [SLOTS];
    logic [31:0] sent_at [SLOTS];
    logic [7:0]  tx_count [SLOTS];
    int unsigned oldest;
    logic [31:0] send_seq;
    int unsigned used;
    logic [15:0] unacked;
    logic [15:0] peer_win;
    logic [31:0] now;

    sws_out_t expected_words[$];
    sws_in_t  send_q[$];
    int errors = 0;
    int words_in = 0;
    int words_queued = 0;
    int words_shown = 0;
    int words_out = 0;
    int retx_seen = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_recv = 1'b0;

    function automatic void model_reset();
        rto_reg = RTO_RESET;
        first_seq_reg = FIRST_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            free_slot[i] = 1'b1;
            seq_slot[i] = '0;
            len_slot[i] = '0;
            sent_at[i] = '0;
            tx_count[i] = '0;
        end
        oldest = 0;
        send_seq = FIRST_RESET;
        used = 0;
        unacked = '0;
        peer_win = PEER_WIN_INIT;
        now = '0;
    endfunction

    function automatic logic [31:0] base_seq();
        return (used > 0) ? seq_slot[oldest] : send_seq;
    endfunction

    function automatic void push_word(logic [2:0] kind, logic [31:0] seq,
                                      logic [10:0] len, logic [7:0] retr, logic lst);
        sws_out_t w;
        w.kind = kind;
        w.seq_out = seq;
        w.len_out = len;
        w.retries = retr;
        w.in_flight = used[3:0];
        w.bytes_out = unacked;
        w.last = lst;
        expected_words.push_back(w);
    endfunction

    // predict the words caused by one accepted input word
    function automatic void predict_sender(sws_in_t w);
        int unsigned idx;
        logic [10:0] len;
        int n;
        logic [31:0] diff;
        case (w.cmd)
            CMD_OFFER: begin
                len = (w.seg_len > MAX_SEG) ? 11'(MAX_SEG) : w.seg_len;
                idx = (oldest + used) % SLOTS;
                if (used >= SLOTS || !free_slot[idx])
                    push_word(KIND_FULL, base_seq(), '0, '0, 1'b1);
                else if ({1'b0, unacked} + 17'(len) > {1'b0, peer_win})
                    push_word(KIND_FLOW, base_seq(), '0, '0, 1'b1);
                else begin
                    seq_slot[idx] = send_seq;
                    send_seq = send_seq + 1;
                    len_slot[idx] = len;
                    free_slot[idx] = 1'b0;
                    tx_count[idx] = 8'd1;
                    sent_at[idx] = now;
                    used++;
                    unacked = unacked + 16'(len);
                    push_word(KIND_SENT, seq_slot[idx], len, 8'd1, 1'b1);
                end
            end
            CMD_ACK: begin
                peer_win = w.adv_window;
                while (used > 0) begin
                    diff = w.ack_number - seq_slot[oldest];
                    if (diff[31]) break;
                    free_slot[oldest] = 1'b1;
                    unacked = unacked - 16'(len_slot[oldest]);
                    used--;
                    oldest = (oldest + 1) % SLOTS;
                end
                push_word(KIND_ACKED, base_seq(), '0, '0, 1'b1);
            end
            CMD_TICK: begin
                n = 0;
                now = now + 1;
                for (int i = 0; i < used; i++) begin
                    idx = (oldest + i) % SLOTS;
                    if (!free_slot[idx] && (now - sent_at[idx]) >= 32'(rto_reg)) begin
                        sent_at[idx] = now;
                        if (tx_count[idx] != 8'd255) tx_count[idx]++;
                        push_word(KIND_RETX, seq_slot[idx], len_slot[idx],
                                  tx_count[idx], 1'b0);
                        n++;
                    end
                end
                if (n == 0)
                    push_word(KIND_IDLE, base_seq(), '0, '0, 1'b1);
                else
                    expected_words[$].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // receiver readiness
    always @(negedge aclk) begin
        if (hold_recv)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // input monitor, predicts at every accepted word
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_sender(s_data);
            words_in++;
        end
    end

    // input driver, next queued word once the shown one is taken
    always @(negedge aclk) begin
        if (!s_valid || words_in == words_shown) begin
            if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= send_q.pop_front();
                words_shown++;
            end else
                s_valid <= 1'b0;
        end
    end

    // result checker
    always @(posedge aclk) begin
        sws_out_t e;
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (m_data.kind == KIND_RETX) retx_seen++;
            if (expected_words.size() == 0) begin
                $error("unexpected result word kind=%0d", m_data.kind);
                errors++;
            end else begin
                e = expected_words.pop_front();
                if (m_data.kind !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, m_data.kind); errors++;
                end
                if (m_data.seq_out !== e.seq_out) begin
                    $error("seq_out exp %0h got %0h", e.seq_out, m_data.seq_out); errors++;
                end
                if (m_data.len_out !== e.len_out) begin
                    $error("len_out exp %0d got %0d", e.len_out, m_data.len_out); errors++;
                end
                if (m_data.retries !== e.retries) begin
                    $error("retries exp %0d got %0d", e.retries, m_data.retries); errors++;
                end
                if (m_data.in_flight !== e.in_flight) begin
                    $error("in_flight exp %0d got %0d", e.in_flight, m_data.in_flight);
                    errors++;
                end
                if (m_data.bytes_out !== e.bytes_out) begin
                    $error("bytes_out exp %0d got %0d", e.bytes_out, m_data.bytes_out);
                    errors++;
                end
                if (m_data.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, m_data.last); errors++;
                end
            end
        end
    end

    // queue one input word and wait until it is accepted
    task automatic send_word(sws_in_t w);
        int target;
        send_q.push_back(w);
        words_queued++;
        target = words_queued;
        wait (words_in >= target);
    endtask

    task automatic send_cmd(logic [1:0] c, logic [10:0] len, logic [31:0] ackn,
                            logic [15:0] win);
        sws_in_t w;
        w.cmd = c;
        w.seg_len = len;
        w.ack_number = ackn;
        w.adv_window = win;
        send_word(w);
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_RTO)
            rto_reg = val[15:0];
        else begin
            first_seq_reg = val;
            if (used == 0) send_seq = val;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // random word, mostly well formed offers, acks and ticks
    task automatic send_random();
        int r;
        logic [31:0] ackn;
        r = $urandom_range(99);
        if (r < 40)
            send_cmd(CMD_OFFER, ($urandom_range(9) == 0) ? 11'($urandom) :
                     11'($urandom_range(MAX_SEG)), $urandom, 16'($urandom));
        else if (r < 65) begin
            ackn = base_seq() + $urandom_range(used) - 1;
            if ($urandom_range(9) == 0) ackn = $urandom;
            send_cmd(CMD_ACK, 11'($urandom),
                     ackn, ($urandom_range(3) == 0) ? 16'($urandom) : 16'hffff);
        end else if (r < 97)
            send_cmd(CMD_TICK, 11'($urandom), $urandom, 16'($urandom));
        else
            send_cmd(CMD_NONE, 11'($urandom), $urandom, 16'($urandom));
    endtask

    task automatic test_directed();
        send_cmd(CMD_TICK, '0, '0, '0);
        send_cmd(CMD_OFFER, 11'd0, '0, '0);
        send_cmd(CMD_OFFER, 11'd2047, '1, '1);
        send_cmd(CMD_OFFER, 11'd1, '0, '0);
        send_cmd(CMD_NONE, '1, '1, '1);
        for (int i = 0; i < 6; i++) send_cmd(CMD_OFFER, 11'd1024, '0, '0);
        send_cmd(CMD_OFFER, 11'd5, '0, '0);
        send_cmd(CMD_ACK, '0, send_seq - 6, 16'd0);
        send_cmd(CMD_OFFER, 11'd1, '0, '0);
        send_cmd(CMD_ACK, '0, send_seq - 1, 16'hffff);
        send_cmd(CMD_ACK, '0, send_seq + 100, 16'h8000);
        send_cmd(CMD_ACK, '0, send_seq + 32'h8000_0000, 16'h7fff);
        send_cmd(CMD_TICK, '1, '1, '1);
    endtask

    task automatic test_timeouts();
        write_reg(CFG_RTO, 32'd0);
        write_reg(CFG_FIRST, 32'hffff_fffd);
        for (int i = 0; i < 5; i++) send_cmd(CMD_OFFER, 11'($urandom_range(MAX_SEG)), '0, '0);
        for (int i = 0; i < 4; i++) send_cmd(CMD_TICK, '0, '0, '0);
        write_reg(CFG_FIRST, 32'h1234_5678);
        send_cmd(CMD_ACK, '0, 32'd1, 16'hffff);
        write_reg(CFG_RTO, 32'd3);
        write_reg(CFG_FIRST, 32'h7fff_ffff);
    endtask

    task automatic test_random(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n) send_random();
    endtask

    task automatic test_backpressure();
        int k;
        wait_drained();
        send_idle_pct = 0;
        hold_recv = 1'b1;
        fork
            begin
                repeat (300) @(negedge aclk);
                hold_recv = 1'b0;
            end
            for (k = 0; k < 12; k++) send_cmd(CMD_TICK, '0, '0, '0);
        join
        wait_drained();
    endtask

    initial begin
        model_reset();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_idle_pct = 37;
        recv_idle_pct = 61;
        test_directed();
        test_timeouts();
        test_random(80, 37, 61);
        write_reg(CFG_RTO, 32'd65535);
        write_reg(CFG_FIRST, 32'd0);
        test_random(60, 61, 37);
        write_reg(CFG_RTO, 32'd2);
        test_backpressure();
        test_random(80, 0, 0);
        wait_drained();
        $display("covered %0d input words, %0d result words, %0d retransmits",
                 words_in, words_out, retx_seen);
        $display("config extremes, full and flow-blocked windows, zero timeout, output stall");
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #1ms;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
